### src/halo_pkg.sv
package halo_pkg;

    // Design limits.
    localparam int MAX_INTERIOR = 16;
    localparam int MAX_GUARD    = 4;
    localparam int MAX_RESULTS  = 64;

    // Field and register widths.
    localparam int DIM_W      = 5;
    localparam int GUARD_W    = 3;
    localparam int GRID_W     = 10;
    localparam int BUF_W      = 6;
    localparam int DIR_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GUARD_WIDTH   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [DIM_W-1:0]   COLS_RESET  = 5'd10;
    localparam logic [DIM_W-1:0]   ROWS_RESET  = 5'd10;
    localparam logic [GUARD_W-1:0] GUARD_RESET = 3'd2;

    // Operation codes.
    localparam logic OP_PACK   = 1'b0;
    localparam logic OP_UNPACK = 1'b1;

    // Neighbor directions.
    typedef enum logic [DIR_W-1:0] {
        DIR_LEFT         = 3'd0,
        DIR_RIGHT        = 3'd1,
        DIR_UP           = 3'd2,
        DIR_DOWN         = 3'd3,
        DIR_TOP_LEFT     = 3'd4,
        DIR_TOP_RIGHT    = 3'd5,
        DIR_BOTTOM_LEFT  = 3'd6,
        DIR_BOTTOM_RIGHT = 3'd7
    } dir_t;

    // Placement of a strip along one axis.
    typedef enum logic [1:0] {
        SIDE_SPAN = 2'd0,
        SIDE_LOW  = 2'd1,
        SIDE_HIGH = 2'd2
    } side_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SETUP = 2'd1,
        ST_RUN   = 2'd2
    } state_t;

    // Input transaction payload.
    typedef struct packed {
        logic             opcode;
        logic [DIR_W-1:0] direction;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic [GRID_W-1:0] grid_index;
        logic [BUF_W-1:0]  buffer_index;
        logic              last;
    } out_item_t;

    // Start and length of a strip along one axis.
    typedef struct packed {
        logic [DIM_W-1:0] start;
        logic [DIM_W-1:0] len;
    } span_t;

    // Row placement of the strip for each direction.
    function automatic side_t vert_side(input dir_t d);
        side_t s;
        case (d)
            DIR_LEFT, DIR_RIGHT:                s = SIDE_SPAN;
            DIR_UP, DIR_TOP_LEFT, DIR_TOP_RIGHT: s = SIDE_LOW;
            default:                            s = SIDE_HIGH;
        endcase
        return s;
    endfunction

    // Column placement of the strip for each direction.
    function automatic side_t horz_side(input dir_t d);
        side_t s;
        case (d)
            DIR_UP, DIR_DOWN:                        s = SIDE_SPAN;
            DIR_LEFT, DIR_TOP_LEFT, DIR_BOTTOM_LEFT: s = SIDE_LOW;
            default:                                 s = SIDE_HIGH;
        endcase
        return s;
    endfunction

endpackage

### src/halo_pack_unpack_address_gen.sv
// Halo address generator for a 2-D tile padded on every side by a guard band.
// Each input transaction names a neighbor direction and pack or unpack; the
// block then emits, one per output transaction, the row-major padded-grid
// index, the buffer position and a last flag for every cell of that strip.
// After an input is accepted the block places the strip in its setup state,
// then issues one address per cycle while the output is taken; a strip holds
// up to 64 cells. A single running index adder walks the strip; in_ready is
// low until the final address has been loaded into the output register.
// Register values outside their ranges are clamped, and the guard is limited
// to the smaller interior size.
module halo_pack_unpack_address_gen
    import halo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    // Configuration registers.
    logic [DIM_W-1:0]   cols_reg;
    logic [DIM_W-1:0]   rows_reg;
    logic [GUARD_W-1:0] guard_reg;

    // Sequencer state and latched transaction parameters.
    state_t             state_reg, state_next;
    logic               unpack_reg, unpack_next;
    dir_t               dir_reg, dir_next;
    logic [DIM_W-1:0]   nx_reg, nx_next;
    logic [DIM_W-1:0]   ny_reg, ny_next;
    logic [GUARD_W-1:0] g_reg, g_next;

    // Walk registers.
    logic [DIM_W-1:0]  h_reg, h_next;
    logic [DIM_W-1:0]  w_reg, w_next;
    logic [DIM_W-1:0]  skip_reg, skip_next;
    logic [DIM_W-1:0]  r_reg, r_next;
    logic [DIM_W-1:0]  c_reg, c_next;
    logic [GRID_W-1:0] idx_reg, idx_next;
    logic [BUF_W-1:0]  count_reg, count_next;

    // Output register.
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    // Decoded control.
    logic             in_fire;
    logic             slot_free;
    logic             emit;
    logic             row_end;
    logic             run_last;
    logic [DIM_W-1:0] nx_eff;
    logic [DIM_W-1:0] ny_eff;
    logic [DIM_W-1:0] g_eff;
    logic [DIM_W-1:0] total_x;
    span_t            rspan;
    span_t            cspan;

    // Clamp an interior size to its legal range.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0)
        begin
            res = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_INTERIOR))
        begin
            res = DIM_W'(MAX_INTERIOR);
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

    // Start and length of a strip along one axis.
    function automatic span_t axis_span(input side_t side, input logic unpack,
                                        input logic [DIM_W-1:0] n,
                                        input logic [GUARD_W-1:0] g);
        span_t sp;
        case (side)
            SIDE_SPAN:
            begin
                sp.start = DIM_W'(g);
                sp.len   = n;
            end
            SIDE_LOW:
            begin
                sp.start = unpack ? '0 : DIM_W'(g);
                sp.len   = DIM_W'(g);
            end
            default:
            begin
                sp.start = unpack ? n + DIM_W'(g) : n;
                sp.len   = DIM_W'(g);
            end
        endcase
        return sp;
    endfunction

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= COLS_RESET;
            rows_reg  <= ROWS_RESET;
            guard_reg <= GUARD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INTERIOR_COLS: cols_reg  <= cfg_data;
                REG_INTERIOR_ROWS: rows_reg  <= cfg_data;
                REG_GUARD_WIDTH:   guard_reg <= cfg_data[GUARD_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective tile sizes from the configuration.
    always_comb
    begin
        nx_eff = clamp_dim(cols_reg);
        ny_eff = clamp_dim(rows_reg);
        if (guard_reg == '0)
        begin
            g_eff = DIM_W'(1);
        end
        else if (guard_reg > GUARD_W'(MAX_GUARD))
        begin
            g_eff = DIM_W'(MAX_GUARD);
        end
        else
        begin
            g_eff = DIM_W'(guard_reg);
        end
        if (g_eff > nx_eff)
        begin
            g_eff = nx_eff;
        end
        if (g_eff > ny_eff)
        begin
            g_eff = ny_eff;
        end
    end

    // Strip placement for the latched transaction.
    always_comb
    begin
        rspan   = axis_span(vert_side(dir_reg), unpack_reg, ny_reg, g_reg);
        cspan   = axis_span(horz_side(dir_reg), unpack_reg, nx_reg, g_reg);
        total_x = nx_reg + DIM_W'({g_reg, 1'b0});
    end

    // Handshake and walk status.
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = (state_reg == ST_RUN) && slot_free;
    assign row_end   = (c_reg == w_reg - DIM_W'(1));
    assign run_last  = row_end && (r_reg == h_reg - DIM_W'(1));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (emit && run_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = out_valid_reg;
        out_data  = out_data_reg;
    end

    // Datapath: latch parameters, place the strip, then walk it.
    always_comb
    begin
        unpack_next    = unpack_reg;
        dir_next       = dir_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        g_next         = g_reg;
        h_next         = h_reg;
        w_next         = w_reg;
        skip_next      = skip_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (in_fire)
        begin
            unpack_next = (in_data.opcode == OP_UNPACK);
            dir_next    = dir_t'(in_data.direction);
            nx_next     = nx_eff;
            ny_next     = ny_eff;
            g_next      = g_eff[GUARD_W-1:0];
        end

        if (state_reg == ST_SETUP)
        begin
            h_next     = rspan.len;
            w_next     = cspan.len;
            skip_next  = total_x - cspan.len + DIM_W'(1);
            r_next     = '0;
            c_next     = '0;
            count_next = '0;
            idx_next   = GRID_W'(rspan.start) * GRID_W'(total_x)
                       + GRID_W'(cspan.start);
        end

        if (emit)
        begin
            out_valid_next             = 1'b1;
            out_data_next.grid_index   = idx_reg;
            out_data_next.buffer_index = count_reg;
            out_data_next.last         = run_last;
            count_next                 = count_reg + BUF_W'(1);
            if (row_end)
            begin
                c_next   = '0;
                r_next   = r_reg + DIM_W'(1);
                idx_next = idx_reg + GRID_W'(skip_reg);
            end
            else
            begin
                c_next   = c_reg + DIM_W'(1);
                idx_next = idx_reg + GRID_W'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        unpack_reg   <= unpack_next;
        dir_reg      <= dir_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        g_reg        <= g_next;
        h_reg        <= h_next;
        w_reg        <= w_next;
        skip_reg     <= skip_next;
        r_reg        <= r_next;
        c_reg        <= c_next;
        idx_reg      <= idx_next;
        count_reg    <= count_next;
        out_data_reg <= out_data_next;
    end

endmodule
